// ===== hw/rtl/l2h_pkg.sv =====
// Shared types and constants of the log2 latency histogram.
`timescale 1ns / 1ps
package l2h_pkg;

  // Command codes carried on the slave-side tuser
  localparam logic [1:0] CMD_RECORD  = 2'd0;
  localparam logic [1:0] CMD_PCTILE  = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Fixed field widths of a transfer
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned QUANT_W = 17;
  localparam int unsigned BIDX_W  = 5;

  // Percentile running sum saturates at 64 bits; comparison is done at 81 bits
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CMP_W   = 81;

  // Wide enough for any bucket number or log2 result
  localparam int unsigned NUM_W   = 7;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the incoming transfer
    logic rec_read;   // read the bucket a sample falls into
    logic rec_write;  // write back the incremented bucket, update min/max/count
    logic prep;       // form count*quantile, clear the walk
    logic walk_read;  // read the next bucket of the walk
    logic walk_add;   // add the bucket to the running sum
    logic rd_read;    // read the requested bucket
    logic finish;     // load the result register
  } l2h_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;     // captured command
    logic       walk_go; // walk continues with another bucket
  } l2h_sts_t;

endpackage

// ===== hw/rtl/log2_latency_histogram.sv =====
// Top level of the power-of-two bucket latency histogram.
`timescale 1ns / 1ps
// Latency histogram with power-of-two buckets. A record transfer adds one to
// bucket floor(log2 sample) (samples 0 and 1 land in bucket 0, anything past
// the top lands in the last bucket) and updates the minimum, maximum and
// sample count. A percentile transfer walks the buckets from the bottom while
// running_sum*65536 <= count*quantile and answers 2^(buckets visited - 1); an
// empty histogram walks every bucket. A read transfer answers one bucket
// count, zero for an index of BUCKETS or more. Every result also carries the
// minimum, maximum and count, and all counters saturate. The block works on
// one transfer at a time and takes the next one in the cycle after its result
// is loaded. A read or unused command goes from decode straight to its result;
// a record reads its bucket and writes it back. A percentile query walks the
// buckets through the single read port of the bucket RAM, one read and one add
// per bucket visited, and visits at most BUCKETS buckets.
// The result sits in an output register, so the next transfer is taken while
// it waits; that transfer then holds in its final state, with the input not
// ready, until the register drains.
// The bucket RAM needs no clearing pass: a valid flag per bucket, cleared at
// reset, makes an unwritten bucket read as zero.
module log2_latency_histogram
  import l2h_pkg::*;
#(
  parameter int unsigned BUCKETS     = 32,
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] sample, [48:32] quantile, [53:49] bucket_index, [55:54] zero
  input  logic [55:0]  s_axis_tdata,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] value, [63:32] smallest, [95:64] largest, [127:96] sample_count
  output logic [127:0] m_axis_tdata
);

  l2h_ctl_t ctl;
  l2h_sts_t sts;

  // Sequence each transfer and hold the result valid flag
  l2h_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Bucket store, statistics, percentile walk and result register
  l2h_dpath #(
    .BUCKETS     (BUCKETS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .command_i      (s_axis_tuser),
    .sample_i       (s_axis_tdata[31:0]),
    .quantile_i     (s_axis_tdata[48:32]),
    .bucket_index_i (s_axis_tdata[53:49]),
    .value_o        (m_axis_tdata[31:0]),
    .smallest_o     (m_axis_tdata[63:32]),
    .largest_o      (m_axis_tdata[95:64]),
    .sample_count_o (m_axis_tdata[127:96])
  );

endmodule

// ===== hw/rtl/l2h_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module l2h_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/l2h_ctrl.sv =====
// Sequencing state machine of the log2 latency histogram.
`timescale 1ns / 1ps
module l2h_ctrl
  import l2h_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  l2h_sts_t sts_i,
  output l2h_ctl_t ctl_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_REC_WR   = 3'd2;
  localparam logic [2:0] S_WALK_CHK = 3'd3;
  localparam logic [2:0] S_WALK_ADD = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       out_free;

  // Result register can take a new result when empty or being drained
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    out_vld_d = out_vld_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.cmd)
          CMD_RECORD: begin
            ctl_o.rec_read = 1'b1;
            state_d        = S_REC_WR;
          end
          CMD_PCTILE: begin
            ctl_o.prep = 1'b1;
            state_d    = S_WALK_CHK;
          end
          CMD_READ: begin
            ctl_o.rd_read = 1'b1;
            state_d       = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_REC_WR: begin
        ctl_o.rec_write = 1'b1;
        state_d         = S_DONE;
      end
      S_WALK_CHK: begin
        if (sts_i.walk_go) begin
          ctl_o.walk_read = 1'b1;
          state_d         = S_WALK_ADD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK_ADD: begin
        ctl_o.walk_add = 1'b1;
        state_d        = S_WALK_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          ctl_o.finish = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ===== hw/rtl/l2h_dpath.sv =====
// Datapath of the log2 latency histogram: bucket store, statistics, walk, result.
`timescale 1ns / 1ps
module l2h_dpath
  import l2h_pkg::*;
#(
  parameter int unsigned BUCKETS     = 32,
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  l2h_ctl_t           ctl_i,
  output l2h_sts_t           sts_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [FIELD_W-1:0] sample_i,
  input  logic [QUANT_W-1:0] quantile_i,
  input  logic [BIDX_W-1:0]  bucket_index_i,
  output logic [FIELD_W-1:0] value_o,
  output logic [FIELD_W-1:0] smallest_o,
  output logic [FIELD_W-1:0] largest_o,
  output logic [FIELD_W-1:0] sample_count_o
);

  localparam int unsigned IDX_W  = $clog2(BUCKETS);
  localparam int unsigned STEP_W = $clog2(BUCKETS + 1);
  localparam int unsigned RHS_W  = COUNT_BITS + QUANT_W;

  // Captured transfer
  logic [CMD_W-1:0]       cmd_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [QUANT_W-1:0]     quant_q;
  logic [BIDX_W-1:0]      bidx_q;

  // Statistics
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;

  // Walk state
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [RHS_W-1:0]  rhs_q;
  logic [IDX_W-1:0]  bkt_q;

  // Bucket store and its valid bits
  logic [BUCKETS-1:0]    vld_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      raddr;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] eff_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;

  logic [NUM_W-1:0]       lg;
  logic [IDX_W-1:0]       bkt_sel;
  logic [NUM_W-1:0]       idx_ext;
  logic                   idx_in_rng;
  logic [ACC_W:0]         acc_sum;
  logic [CMP_W-1:0]       cmp_lhs;
  logic [CMP_W-1:0]       cmp_rhs;
  logic [STEP_W-1:0]      shamt;
  logic [NUM_W-1:0]       shamt_ext;
  logic [FIELD_W-1:0]     value_d;
  logic [FIELD_W-1:0]     res_val_q;
  logic [SAMPLE_BITS-1:0] res_min_q;
  logic [SAMPLE_BITS-1:0] res_max_q;
  logic [COUNT_BITS-1:0]  res_cnt_q;

  // Highest set bit of the sample, samples 0 and 1 give bucket 0
  always_comb begin
    lg = '0;
    for (int i = 1; i < SAMPLE_BITS; i++) begin
      if (smp_q[i]) begin
        lg = NUM_W'(i);
      end
    end
  end

  // Clamp to the last bucket
  assign bkt_sel = (lg > NUM_W'(BUCKETS - 1)) ? IDX_W'(BUCKETS - 1) : lg[IDX_W-1:0];

  assign idx_ext    = NUM_W'(bidx_q);
  assign idx_in_rng = idx_ext < NUM_W'(BUCKETS);

  always_comb begin
    raddr = bkt_sel;
    if (ctl_i.walk_read) begin
      raddr = steps_q[IDX_W-1:0];
    end else if (ctl_i.rd_read) begin
      raddr = idx_ext[IDX_W-1:0];
    end
  end

  l2h_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.rec_write),
    .waddr_i (bkt_q),
    .wdata_i (inc_cnt),
    .re_i    (ctl_i.rec_read | ctl_i.walk_read | ctl_i.rd_read),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // An entry never written since reset reads as zero
  assign eff_cnt = rd_vld_q ? rdata : '0;
  assign inc_cnt = (eff_cnt == '1) ? eff_cnt : COUNT_BITS'(eff_cnt + 1'b1);

  // Saturating running sum
  assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(eff_cnt);

  // running_sum * 65536 <= total * quantile
  assign cmp_lhs = CMP_W'({acc_q, {FRAC_W{1'b0}}});
  assign cmp_rhs = CMP_W'(rhs_q);
  assign sts_o.walk_go = (steps_q < STEP_W'(BUCKETS)) && (cmp_lhs <= cmp_rhs);
  assign sts_o.cmd     = cmd_q;

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    steps_d = steps_q;
    if (ctl_i.rec_write) begin
      if (smp_q < min_q) begin
        min_d = smp_q;
      end
      if (smp_q > max_q) begin
        max_d = smp_q;
      end
      if (cnt_q != '1) begin
        cnt_d = COUNT_BITS'(cnt_q + 1'b1);
      end
    end
    if (ctl_i.prep) begin
      acc_d   = '0;
      steps_d = '0;
    end else if (ctl_i.walk_add) begin
      acc_d   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      steps_d = STEP_W'(steps_q + 1'b1);
    end
  end

  // Percentile answer is 2^(steps-1), at least bucket 0
  assign shamt     = (steps_q == '0) ? '0 : STEP_W'(steps_q - 1'b1);
  assign shamt_ext = NUM_W'(shamt);

  always_comb begin
    value_d = '0;
    case (cmd_q)
      CMD_PCTILE: begin
        if (shamt_ext < NUM_W'(FIELD_W)) begin
          value_d = FIELD_W'(1) << shamt_ext[$clog2(FIELD_W)-1:0];
        end
      end
      CMD_READ: begin
        if (idx_in_rng) begin
          value_d = FIELD_W'(eff_cnt);
        end
      end
      default: begin
        value_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '1;
      max_q    <= '0;
      cnt_q    <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      cnt_q <= cnt_d;
      if (ctl_i.rec_write) begin
        vld_q[bkt_q] <= 1'b1;
      end
      if (ctl_i.rec_read | ctl_i.walk_read | ctl_i.rd_read) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= command_i;
      smp_q   <= SAMPLE_BITS'(sample_i);
      quant_q <= quantile_i;
      bidx_q  <= bucket_index_i;
    end
    if (ctl_i.rec_read) begin
      bkt_q <= bkt_sel;
    end
    if (ctl_i.prep) begin
      rhs_q <= RHS_W'(cnt_q) * RHS_W'(quant_q);
    end
    acc_q   <= acc_d;
    steps_q <= steps_d;
    if (ctl_i.finish) begin
      res_val_q <= value_d;
      res_min_q <= min_q;
      res_max_q <= max_q;
      res_cnt_q <= cnt_q;
    end
  end

  assign value_o        = res_val_q;
  assign smallest_o     = FIELD_W'(res_min_q);
  assign largest_o      = FIELD_W'(res_max_q);
  assign sample_count_o = FIELD_W'(res_cnt_q);

endmodule
